>>> design/bis_pkg.sv
package bis_pkg;

   // default source image limits
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // field and datapath widths
   localparam int DIM_W    = 9;
   localparam int STEP_W   = 24;
   localparam int OUTC_W   = 10;
   localparam int POS_W    = 35;
   localparam int COORD_W  = 18;
   localparam int ROWOFS_W = 27;
   localparam int LIN_W    = 28;
   localparam int AREA_W   = 18;
   localparam int FRAC_W   = 16;
   localparam int WT_W     = 33;
   localparam int ACC_W    = 40;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 24;

   // result queue
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PW    = 3;
   localparam int RSP_CW    = 4;

   // item kinds
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_AW-1:0] REG_STEP_X     = 3'd2;
   localparam logic [CSR_AW-1:0] REG_STEP_Y     = 3'd3;
   localparam logic [CSR_AW-1:0] REG_HAS_ALPHA  = 3'd4;

   // one item after the coordinate and row offset maths
   typedef struct packed {
      logic                func;
      logic [15:0]         idx;
      logic [31:0]         rgba;
      logic [COORD_W-1:0]  x0;
      logic [COORD_W-1:0]  x1;
      logic [ROWOFS_W-1:0] y0w;
      logic [ROWOFS_W-1:0] y1w;
      logic [AREA_W-1:0]   area;
      logic [FRAC_W-1:0]   fx;
      logic [FRAC_W-1:0]   fy;
   } bis_job_type;

   // one corner beat aligned with the memory read data
   typedef struct packed {
      logic            valid;
      logic            first;
      logic            last;
      logic            oor;
      logic [WT_W-1:0] weight;
   } bis_tok_type;

endpackage

>>> design/bis_addr.sv
module bis_addr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_func,
   input  logic [15:0]                 in_idx,
   input  logic [31:0]                 in_rgba,
   input  logic [bis_pkg::OUTC_W-1:0]  in_x,
   input  logic [bis_pkg::OUTC_W-1:0]  in_y,
   input  logic [bis_pkg::STEP_W-1:0]  step_x,
   input  logic [bis_pkg::STEP_W-1:0]  step_y,
   input  logic [bis_pkg::DIM_W-1:0]   width,
   input  logic [bis_pkg::DIM_W-1:0]   height,
   output logic                        out_valid,
   input  logic                        out_ready,
   output bis_pkg::bis_job_type        out_job
);
   import bis_pkg::*;

   logic             m_valid_ff;
   logic             m_func_ff;
   logic [15:0]      m_idx_ff;
   logic [31:0]      m_rgba_ff;
   logic [POS_W-1:0] m_px_ff, m_py_ff;
   logic [POS_W-1:0] px_in, py_in;
   logic             j_valid_ff;
   bis_job_type      job_ff, job_in;
   logic             j_ready;
   logic [COORD_W-1:0] x0, y0, y1;
   logic [COORD_W:0]   x0p, y0p;
   logic [DIM_W-1:0]   wm1, hm1;

   assign j_ready  = !j_valid_ff || out_ready;
   assign in_ready = !m_valid_ff || j_ready;

   // source position in Q.17: (2*out + 1) * step
   assign px_in = POS_W'({in_x, 1'b1}) * POS_W'(step_x);
   assign py_in = POS_W'({in_y, 1'b1}) * POS_W'(step_y);

   // neighbour coordinates, right and bottom clamped to the edge
   assign x0  = m_px_ff[POS_W-1:17];
   assign y0  = m_py_ff[POS_W-1:17];
   assign x0p = {1'b0, x0} + (COORD_W+1)'(1);
   assign y0p = {1'b0, y0} + (COORD_W+1)'(1);
   assign wm1 = width - DIM_W'(1);
   assign hm1 = height - DIM_W'(1);
   assign y1  = (y0p < (COORD_W+1)'(hm1)) ? y0p[COORD_W-1:0] : COORD_W'(hm1);

   always_comb begin
      job_in      = '0;
      job_in.func = m_func_ff;
      job_in.idx  = m_idx_ff;
      job_in.rgba = m_rgba_ff;
      job_in.x0   = x0;
      job_in.x1   = (x0p < (COORD_W+1)'(wm1)) ? x0p[COORD_W-1:0] : COORD_W'(wm1);
      job_in.y0w  = ROWOFS_W'(y0) * ROWOFS_W'(width);
      job_in.y1w  = ROWOFS_W'(y1) * ROWOFS_W'(width);
      job_in.area = AREA_W'(width) * AREA_W'(height);
      job_in.fx   = m_px_ff[FRAC_W:1];
      job_in.fy   = m_py_ff[FRAC_W:1];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
      end else begin
         if (in_ready) m_valid_ff <= in_valid;
         if (j_ready) j_valid_ff <= m_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         m_func_ff <= in_func;
         m_idx_ff  <= in_idx;
         m_rgba_ff <= in_rgba;
         m_px_ff   <= px_in;
         m_py_ff   <= py_in;
      end
      if (j_ready && m_valid_ff) job_ff <= job_in;
   end

   assign out_valid = j_valid_ff;
   assign out_job   = job_ff;

endmodule

>>> design/bis_fetch.sv
module bis_fetch #(
   parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  bis_pkg::bis_job_type job,
   output bis_pkg::bis_tok_type tok,
   output logic [31:0]          rd_data
);
   import bis_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0]       mem_ff [DEPTH];
   logic              busy_ff;
   logic              func_ff;
   logic              oor_ff;
   logic [1:0]        cnt_ff;
   logic [ADDR_W-1:0] addr_ff [4];
   logic [FRAC_W-1:0] fx_ff, fy_ff;
   logic [15:0]       widx_ff;
   logic [31:0]       rgba_ff;
   logic              done;
   logic [LIN_W-1:0]  lin00, lin01, lin10, lin11;
   logic              oor_in;
   logic [FRAC_W:0]   ix, iy, opa, opb;
   logic [WT_W:0]     wprod;
   bis_tok_type       tok_ff, tok_in;
   logic [31:0]       rd_ff;

   // corner linear indexes and the range check
   assign lin00  = LIN_W'(job.y0w) + LIN_W'(job.x0);
   assign lin01  = LIN_W'(job.y0w) + LIN_W'(job.x1);
   assign lin10  = LIN_W'(job.y1w) + LIN_W'(job.x0);
   assign lin11  = LIN_W'(job.y1w) + LIN_W'(job.x1);
   assign oor_in = (lin00 >= LIN_W'(job.area)) || (lin11 >= LIN_W'(job.area));

   // a write or a forced-black item is done at once, a lookup once all four corners are read
   assign done = busy_ff && (func_ff == FUNC_WRITE || oor_ff || cnt_ff == 2'd3);
   assign job_ready = !busy_ff || done;

   // corner weight: one multiply per beat
   assign ix    = (FRAC_W+1)'(65536) - {1'b0, fx_ff};
   assign iy    = (FRAC_W+1)'(65536) - {1'b0, fy_ff};
   assign opa   = cnt_ff[0] ? {1'b0, fx_ff} : ix;
   assign opb   = cnt_ff[1] ? {1'b0, fy_ff} : iy;
   assign wprod = (WT_W+1)'(opa) * (WT_W+1)'(opb);

   always_comb begin
      tok_in        = '0;
      tok_in.valid  = busy_ff && func_ff == FUNC_READ;
      tok_in.first  = cnt_ff == 2'd0 || oor_ff;
      tok_in.last   = done;
      tok_in.oor    = oor_ff;
      tok_in.weight = wprod[WT_W-1:0];
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (job_ready) busy_ff <= job_valid;
         tok_ff.valid <= tok_in.valid;
      end
   end

   // sequencer payload
   always_ff @(posedge clock) begin
      if (job_ready && job_valid) begin
         func_ff    <= job.func;
         oor_ff     <= oor_in;
         cnt_ff     <= 2'd0;
         addr_ff[0] <= ADDR_W'(lin00);
         addr_ff[1] <= ADDR_W'(lin01);
         addr_ff[2] <= ADDR_W'(lin10);
         addr_ff[3] <= ADDR_W'(lin11);
         fx_ff      <= job.fx;
         fy_ff      <= job.fy;
         widx_ff    <= job.idx;
         rgba_ff    <= job.rgba;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
      tok_ff.first  <= tok_in.first;
      tok_ff.last   <= tok_in.last;
      tok_ff.oor    <= tok_in.oor;
      tok_ff.weight <= tok_in.weight;
   end

   // single-port pixel store
   always_ff @(posedge clock) begin
      if (busy_ff && func_ff == FUNC_WRITE) begin
         if (int'(widx_ff) < DEPTH) mem_ff[ADDR_W'(widx_ff)] <= rgba_ff;
      end else if (busy_ff && !oor_ff) begin
         rd_ff <= mem_ff[addr_ff[cnt_ff]];
      end
   end

   assign tok     = tok_ff;
   assign rd_data = rd_ff;

endmodule

>>> design/bis_blend.sv
module bis_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  bis_pkg::bis_tok_type tok,
   input  logic [31:0]          rd_data,
   input  logic                 has_alpha,
   output logic                 res_valid,
   output logic [7:0]           res_red,
   output logic [7:0]           res_green,
   output logic [7:0]           res_blue,
   output logic                 res_oor
);
   import bis_pkg::*;

   logic [ACC_W-1:0] acc_ff [4];
   logic [ACC_W-1:0] acc_in [4];
   logic             fin_ff, fin_oor_ff;
   logic             out_valid_ff, out_oor_ff;
   logic [7:0]       col_ff [3];
   logic [7:0]       col_in [3];
   logic [7:0]       alpha;
   logic [15:0]      prod [3];
   logic [16:0]      quot [3];

   // weighted corner accumulation, channel k from the top byte down
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         acc_in[k] = (tok.first ? ACC_W'(0) : acc_ff[k])
                   + ACC_W'(rd_data[31-8*k -: 8]) * ACC_W'(tok.weight);
      end
   end

   // alpha blend onto black, floor(c*a/255)
   assign alpha = has_alpha ? acc_ff[3][ACC_W-1:32] : 8'hFF;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k]   = 16'(acc_ff[k][ACC_W-1:32]) * 16'(alpha);
         quot[k]   = (17'(prod[k]) + 17'(prod[k][15:8]) + 17'd1) >> 8;
         col_in[k] = (alpha < 8'hFF) ? quot[k][7:0] : acc_ff[k][ACC_W-1:32];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fin_ff       <= tok.valid && tok.last;
         out_valid_ff <= fin_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (tok.valid) begin
         for (int k = 0; k < 4; k++) acc_ff[k] <= acc_in[k];
      end
      fin_oor_ff <= tok.oor;
      out_oor_ff <= fin_oor_ff;
      for (int k = 0; k < 3; k++) col_ff[k] <= fin_oor_ff ? 8'd0 : col_in[k];
   end

   assign res_valid = out_valid_ff;
   assign res_red   = col_ff[0];
   assign res_green = col_ff[1];
   assign res_blue  = col_ff[2];
   assign res_oor   = out_oor_ff;

endmodule

>>> design/bilinear_image_scaler.sv
// a request reads its four corners in turn on the single pixel memory port, none
// when out of range; a pixel write returns nothing; the fetch takes the next item only as the current one finishes
// reset: synchronous, active high; clears control state and registers to defaults
// the pixel store is not cleared and holds undefined data until written
module bilinear_image_scaler #(
   parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // pixel_index 15:0, pixel_rgba 47:16, out_x 57:48, out_y 67:58
   input  logic [71:0]                 req_tdata,
   // func
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // red 7:0, green 15:8, blue 23:16
   output logic [23:0]                 rsp_tdata,
   // out_of_range
   output logic                        rsp_tuser,
   input  logic                        csr_we,
   input  logic [bis_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [bis_pkg::CSR_DW-1:0]  csr_wdata
);
   import bis_pkg::*;

   logic [DIM_W-1:0]  width_ff, height_ff, width, height;
   logic [STEP_W-1:0] step_x_ff, step_y_ff;
   logic              has_alpha_ff;
   logic              a_ready, j_valid, j_ready;
   bis_job_type       job;
   bis_tok_type       tok;
   logic [31:0]       rd_data;
   logic              res_valid, res_oor;
   logic [7:0]        res_red, res_green, res_blue;
   logic [RSP_CW-1:0] flight_ff, count_ff;
   logic [RSP_PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [24:0]       fifo_ff [RSP_DEPTH];
   logic              req_beat, rsp_beat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_W'(256);
         height_ff    <= DIM_W'(256);
         step_x_ff    <= STEP_W'(65536);
         step_y_ff    <= STEP_W'(65536);
         has_alpha_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SRC_WIDTH:  width_ff     <= csr_wdata[DIM_W-1:0];
            REG_SRC_HEIGHT: height_ff    <= csr_wdata[DIM_W-1:0];
            REG_STEP_X:     step_x_ff    <= csr_wdata[STEP_W-1:0];
            REG_STEP_Y:     step_y_ff    <= csr_wdata[STEP_W-1:0];
            REG_HAS_ALPHA:  has_alpha_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // image size, zero read as one and saturated to the limits
   assign width  = (width_ff == '0) ? DIM_W'(1)
                 : (int'(width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign height = (height_ff == '0) ? DIM_W'(1)
                 : (int'(height_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_ff;

   // requests in flight never exceed the result queue
   assign req_tready = a_ready && (flight_ff < RSP_CW'(RSP_DEPTH));
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_tvalid && rsp_tready;

   bis_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && (flight_ff < RSP_CW'(RSP_DEPTH))),
      .in_ready  (a_ready),
      .in_func   (req_tuser),
      .in_idx    (req_tdata[15:0]),
      .in_rgba   (req_tdata[47:16]),
      .in_x      (req_tdata[57:48]),
      .in_y      (req_tdata[67:58]),
      .step_x    (step_x_ff),
      .step_y    (step_y_ff),
      .width     (width),
      .height    (height),
      .out_valid (j_valid),
      .out_ready (j_ready),
      .out_job   (job)
   );

   bis_fetch #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .job_valid (j_valid),
      .job_ready (j_ready),
      .job       (job),
      .tok       (tok),
      .rd_data   (rd_data)
   );

   bis_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .tok       (tok),
      .rd_data   (rd_data),
      .has_alpha (has_alpha_ff),
      .res_valid (res_valid),
      .res_red   (res_red),
      .res_green (res_green),
      .res_blue  (res_blue),
      .res_oor   (res_oor)
   );

   // in-flight count and result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         flight_ff <= flight_ff + RSP_CW'(req_beat && req_tuser == FUNC_READ)
                    - RSP_CW'(rsp_beat);
         count_ff  <= count_ff + RSP_CW'(res_valid) - RSP_CW'(rsp_beat);
         if (res_valid) wr_ptr_ff <= wr_ptr_ff + RSP_PW'(1);
         if (rsp_beat) rd_ptr_ff <= rd_ptr_ff + RSP_PW'(1);
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (res_valid) fifo_ff[wr_ptr_ff] <= {res_oor, res_blue, res_green, res_red};
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = fifo_ff[rd_ptr_ff][23:0];
   assign rsp_tuser  = fifo_ff[rd_ptr_ff][24];

`ifndef ASSERT_OFF
   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= RSP_CW'(RSP_DEPTH))
      else $error("requests in flight exceed result queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (count_ff < RSP_CW'(RSP_DEPTH) || rsp_beat))
      else $error("result queue overflow");
   a_queue_le_flight: assert property (@(posedge clock) disable iff (reset)
      count_ff <= flight_ff)
      else $error("queued results exceed requests in flight");
   a_beat_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> flight_ff != '0)
      else $error("result beat without a request in flight");
`endif

endmodule

>>> sim/bilinear_image_scaler_test.sv
module bilinear_image_scaler_test;
   import bis_pkg::*;

   localparam int                CLK_HALF    = 4;
   localparam int                DIM_MAX     = 256;
   localparam int                DRAIN_WAIT  = 20;
   localparam int                STALL_LIMIT = 5000;
   localparam int                HOLD_CYCLES = 400;
   localparam logic [CSR_AW-1:0] REG_UNUSED  = 3'd7;

   typedef struct {
      logic        func;
      logic [15:0] idx;
      logic [31:0] rgba;
      logic [9:0]  ox;
      logic [9:0]  oy;
   } pixel_beat_t;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       oor;
   } colour_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   bilinear_image_scaler u_top (.*);

   always #CLK_HALF clock = ~clock;

   // shadow of the block state
   logic [31:0] shadow_pixels [0:65535];
   bit          pixel_written [0:65535];
   logic [8:0]  sh_width = 9'd256, sh_height = 9'd256;
   logic [23:0] sh_step_x = 24'd65536, sh_step_y = 24'd65536;
   logic        sh_alpha = 1'b0;

   pixel_beat_t pending_beats [$];
   colour_t     expected_colours [$];
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   function automatic longint unsigned eff_dim(input logic [8:0] v);
      if (v == 0) return 1;
      return (v > DIM_MAX) ? DIM_MAX : v;
   endfunction

   // corner addresses and fractions for an output coordinate; returns out-of-range
   function automatic bit locate(input logic [9:0] ox, input logic [9:0] oy,
                                 output int unsigned idx [4],
                                 output longint unsigned fx, output longint unsigned fy);
      longint unsigned w, h, px, py, x0, y0, x1, y1, total;
      w = eff_dim(sh_width);
      h = eff_dim(sh_height);
      px = (2 * longint'(ox) + 1) * longint'(sh_step_x);
      py = (2 * longint'(oy) + 1) * longint'(sh_step_y);
      x0 = px >> 17;
      y0 = py >> 17;
      fx = (px >> 1) & 64'hFFFF;
      fy = (py >> 1) & 64'hFFFF;
      x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
      total = w * h;
      if (y0 * w + x0 >= total || y1 * w + x1 >= total) return 1'b1;
      idx[0] = y0 * w + x0;
      idx[1] = y0 * w + x1;
      idx[2] = y1 * w + x0;
      idx[3] = y1 * w + x1;
      return 1'b0;
   endfunction

   function automatic longint unsigned mix(input logic [31:0] c [4], input int sh,
                                           input longint unsigned fx,
                                           input longint unsigned fy);
      longint unsigned ix, iy, s;
      ix = 65536 - fx;
      iy = 65536 - fy;
      s = ((c[0] >> sh) & 8'hFF) * ix * iy + ((c[1] >> sh) & 8'hFF) * fx * iy
        + ((c[2] >> sh) & 8'hFF) * ix * fy + ((c[3] >> sh) & 8'hFF) * fx * fy;
      return s >> 32;
   endfunction

   function automatic colour_t shade(input logic [9:0] ox, input logic [9:0] oy);
      colour_t res;
      int unsigned idx [4];
      logic [31:0] c [4];
      longint unsigned fx, fy, r, g, b, a;
      res = '{8'd0, 8'd0, 8'd0, 1'b1};
      if (locate(ox, oy, idx, fx, fy)) return res;
      for (int k = 0; k < 4; k++) c[k] = shadow_pixels[idx[k]];
      r = mix(c, 24, fx, fy);
      g = mix(c, 16, fx, fy);
      b = mix(c, 8, fx, fy);
      a = sh_alpha ? mix(c, 0, fx, fy) : 255;
      if (a < 255) begin
         r = r * a / 255;
         g = g * a / 255;
         b = b * a / 255;
      end
      res = '{r[7:0], g[7:0], b[7:0], 1'b0};
      return res;
   endfunction

   task automatic queue_write(input logic [15:0] idx, input logic [31:0] rgba);
      pending_beats.push_back('{FUNC_WRITE, idx, rgba, 10'($urandom), 10'($urandom)});
      shadow_pixels[idx] = rgba;
      pixel_written[idx] = 1'b1;
   endtask

   // fills in any corner not yet stored, then queues the request
   task automatic queue_request(input logic [9:0] ox, input logic [9:0] oy);
      int unsigned idx [4];
      longint unsigned fx, fy;
      if (!locate(ox, oy, idx, fx, fy))
         for (int k = 0; k < 4; k++)
            if (!pixel_written[idx[k]]) queue_write(16'(idx[k]), $urandom);
      pending_beats.push_back('{FUNC_READ, 16'($urandom), $urandom, ox, oy});
      expected_colours.push_back(shade(ox, oy));
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] addr, input logic [23:0] val);
      case (addr)
         REG_SRC_WIDTH:  sh_width  = val[8:0];
         REG_SRC_HEIGHT: sh_height = val[8:0];
         REG_STEP_X:     sh_step_x = val;
         REG_STEP_Y:     sh_step_y = val;
         REG_HAS_ALPHA:  sh_alpha  = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_geometry(input logic [8:0] w, input logic [8:0] h,
                               input logic [23:0] sx, input logic [23:0] sy,
                               input logic alpha);
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      write_reg(REG_STEP_X, sx);
      write_reg(REG_STEP_Y, sy);
      write_reg(REG_HAS_ALPHA, alpha);
   endtask

   task automatic drain;
      while (pending_beats.size() > 0 || expected_colours.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // random traffic: mostly in-image requests, some noise writes and edge overruns
   task automatic random_burst(input int count);
      int start;
      int xmax, ymax;
      start = pending_beats.size();
      xmax = (sh_step_x == 0) ? 1023 :
             ((eff_dim(sh_width) << 16) / sh_step_x + 1 > 1023) ? 1023 :
             int'((eff_dim(sh_width) << 16) / sh_step_x + 1);
      ymax = (sh_step_y == 0) ? 1023 :
             ((eff_dim(sh_height) << 16) / sh_step_y + 1 > 1023) ? 1023 :
             int'((eff_dim(sh_height) << 16) / sh_step_y + 1);
      while (pending_beats.size() - start < count) begin
         case ($urandom_range(0, 9))
            0:       queue_write(16'($urandom), $urandom);
            1:       queue_request(10'($urandom), 10'($urandom));
            default: queue_request(10'($urandom_range(0, xmax)),
                                   10'($urandom_range(0, ymax)));
         endcase
      end
   endtask

   // input driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) void'(pending_beats.pop_front());
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_beats[0].func;
               req_tdata  <= {4'd0, pending_beats[0].oy, pending_beats[0].ox,
                              pending_beats[0].rgba, pending_beats[0].idx};
               if (idle_on && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   int  rsp_gap = 0;
   bit  hold_done = 1'b0;
   colour_t want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colours.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: rgb %h oor %b", rsp_tdata, rsp_tuser);
            end else begin
               want = expected_colours.pop_front();
               if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                   rsp_tdata[23:16] !== want.blue || rsp_tuser !== want.oor) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp r %h g %h b %h oor %b, got r %h g %h b %h oor %b",
                              want.red, want.green, want.blue, want.oor, rsp_tdata[7:0],
                              rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser);
               end
            end
         end
         if (hold_request && !hold_done) begin
            hold_done  <= 1'b1;
            rsp_gap    <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap    <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_gap    <= $urandom_range(1, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset geometry, image corners and edges
      queue_write(16'h0000, 32'hFFFFFFFF);
      queue_write(16'hFFFF, 32'h00000000);
      queue_request(10'd0, 10'd0);
      queue_request(10'd255, 10'd255);
      queue_request(10'd255, 10'd0);
      queue_request(10'd0, 10'd255);
      queue_request(10'd256, 10'd0);
      queue_request(10'd1023, 10'd1023);
      drain();
      write_reg(REG_UNUSED, 24'hFFFFFF);
      // zero sizes and zero steps, alpha on
      set_geometry(9'd0, 9'd0, 24'd0, 24'd0, 1'b1);
      queue_write(16'd0, 32'h80FF4010);
      queue_request(10'd0, 10'd0);
      queue_request(10'd1023, 10'd1023);
      drain();
      // oversized registers and maximum steps
      set_geometry(9'd511, 9'd511, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
      queue_request(10'd0, 10'd0);
      queue_request(10'd1, 10'd0);
      queue_request(10'd1023, 10'd0);
      drain();
      // a single column, half steps, alpha blend with partial alpha
      set_geometry(9'd1, 9'd256, 24'h008000, 24'h008000, 1'b1);
      queue_write(16'd3, 32'hFF00FF00);
      queue_write(16'd4, 32'h00FF00FF);
      queue_request(10'd0, 10'd6);
      queue_request(10'd0, 10'd7);
      queue_request(10'd1, 10'd511);
      drain();

      // random phases across geometries
      for (int ph = 0; ph < 6; ph++) begin
         set_geometry(($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(1, 24)),
                      ($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(1, 24)),
                      24'($urandom_range(24'h002000, 24'h030000)),
                      24'($urandom_range(24'h002000, 24'h030000)), 1'($urandom));
         if (ph == 2) hold_request = 1'b1;
         if (ph == 5) idle_on = 1'b0;
         random_burst(210);
         drain();
      end

      if (mismatches == 0 && expected_colours.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/bis_pkg.sv
design/bis_addr.sv
design/bis_fetch.sv
design/bis_blend.sv
design/bilinear_image_scaler.sv
sim/bilinear_image_scaler_test.sv
